/* src/lccd_pkg.sv */
package lccd_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CKUP = 3'd1,
    PH_SIDN = 3'd2,
    PH_LOW  = 3'd3,
    PH_HIGH = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL        = 1'd1;

  localparam int CFG_W   = 16;
  localparam int PIX_W   = 7;
  localparam int SAMP_W  = 8;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd450;
  localparam logic [CFG_W-1:0] TAIL_RESET        = 16'd20;
  localparam int               PIXELS_DEFAULT    = 128;

  // One result beat
  typedef struct packed {
    logic              si_level;
    logic              clock_level;
    logic              pixel_valid;
    logic [PIX_W-1:0]  pixel_index;
    logic [SAMP_W-1:0] pixel_value;
    logic              frame_done;
    logic [SAMP_W-1:0] threshold;
    logic              busy_res;
  } res_t;

endpackage

/* src/linear_ccd_readout_threshold_core.sv */
// Linear CCD readout sequencer with frame threshold.
// The result beat for a tick is registered into the result register, or into the skid entry while that is held.
// Throughput: one tick per cycle while the skid entry is empty; sequencer state updates in a single pass per tick.
// A two-entry output buffer (result register plus skid) takes one more tick in under stall.
// Reset (rst_n low, synchronous): phase idle, counters and min/max/threshold zero,
// configuration back to half period 450 and tail 20, output buffer empty.
module linear_ccd_readout_threshold_core #(
  parameter int PIXELS = lccd_pkg::PIXELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [lccd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lccd_pkg::CFG_W-1:0]    cfg_wdata,
  // tick input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_start_req,
  input  logic [lccd_pkg::SAMP_W-1:0]   in_adc_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_si_level,
  output logic                          out_clock_level,
  output logic                          out_pixel_valid,
  output logic [lccd_pkg::PIX_W-1:0]    out_pixel_index,
  output logic [lccd_pkg::SAMP_W-1:0]   out_pixel_value,
  output logic                          out_frame_done,
  output logic [lccd_pkg::SAMP_W-1:0]   out_threshold,
  output logic                          out_busy_res
);
  import lccd_pkg::*;

  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIXELS - 1);

  // configuration registers
  logic [CFG_W-1:0] half_period_r, tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
      tail_r        <= TAIL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata;
        CFG_TAIL:        tail_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [PIX_W-1:0]  pix_cnt_r, pix_cnt_nxt;
  logic [CFG_W-1:0]  dly_cnt_r, dly_cnt_nxt;
  logic [SAMP_W-1:0] max_r, max_nxt, min_r, min_nxt, thr_r, thr_nxt;

  logic              in_acc;
  logic [CFG_W-1:0]  hp_eff, tail_eff, dly_inc;
  logic              hp_hit, tail_hit;
  logic [SAMP_W:0]   mm_sum;
  res_t              res_nxt;

  assign in_acc   = in_valid && in_ready;
  assign hp_eff   = (half_period_r == '0) ? CFG_W'(1) : half_period_r;
  assign tail_eff = (tail_r == '0) ? CFG_W'(1) : tail_r;
  assign dly_inc  = dly_cnt_r + CFG_W'(1);
  assign hp_hit   = dly_inc >= hp_eff;
  assign tail_hit = dly_inc >= tail_eff;
  assign mm_sum   = {1'b0, max_r} + {1'b0, min_r};

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    pix_cnt_nxt = pix_cnt_r;
    dly_cnt_nxt = dly_cnt_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    thr_nxt     = thr_r;
    case (phase_r)
      PH_CKUP: phase_nxt = PH_SIDN;
      PH_SIDN: begin
        pix_cnt_nxt = '0;
        dly_cnt_nxt = '0;
        phase_nxt   = PH_LOW;
      end
      PH_LOW: begin
        dly_cnt_nxt = dly_inc;
        if (hp_hit) begin
          if (pix_cnt_r == '0) begin
            max_nxt = in_adc_sample;
            min_nxt = in_adc_sample;
          end else begin
            if (in_adc_sample > max_r) max_nxt = in_adc_sample;
            if (in_adc_sample < min_r) min_nxt = in_adc_sample;
          end
          dly_cnt_nxt = '0;
          phase_nxt   = PH_HIGH;
        end
      end
      PH_HIGH: begin
        dly_cnt_nxt = dly_inc;
        if (hp_hit) begin
          dly_cnt_nxt = '0;
          if (pix_cnt_r >= LAST_PIX) begin
            phase_nxt = PH_TAIL;
          end else begin
            pix_cnt_nxt = pix_cnt_r + PIX_W'(1);
            phase_nxt   = PH_LOW;
          end
        end
      end
      PH_TAIL: begin
        dly_cnt_nxt = dly_inc;
        if (tail_hit) begin
          thr_nxt     = mm_sum[SAMP_W:1];
          dly_cnt_nxt = '0;
          phase_nxt   = PH_IDLE;
        end
      end
      default: phase_nxt = in_start_req ? PH_CKUP : PH_IDLE;
    endcase
  end

  // result fields for this tick
  always_comb begin
    res_nxt           = '0;
    res_nxt.busy_res  = 1'b1;
    res_nxt.threshold = thr_nxt;
    case (phase_r)
      PH_CKUP: begin
        res_nxt.si_level    = 1'b1;
        res_nxt.clock_level = 1'b1;
      end
      PH_SIDN: res_nxt.clock_level = 1'b1;
      PH_LOW: begin
        if (hp_hit) begin
          res_nxt.pixel_valid = 1'b1;
          res_nxt.pixel_index = pix_cnt_r;
          res_nxt.pixel_value = in_adc_sample;
        end
      end
      PH_HIGH: res_nxt.clock_level = 1'b1;
      PH_TAIL: res_nxt.frame_done = tail_hit;
      default: begin
        res_nxt.si_level = in_start_req;
        res_nxt.busy_res = in_start_req;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pix_cnt_r <= '0;
      dly_cnt_r <= '0;
      max_r     <= '0;
      min_r     <= '0;
      thr_r     <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      dly_cnt_r <= dly_cnt_nxt;
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      thr_r     <= thr_nxt;
    end
  end

  // output buffer: result register plus one skid entry
  res_t out_res_r, skid_res_r;
  logic out_vld_r, skid_vld_r;
  logic out_take;

  assign in_ready = !skid_vld_r;
  assign out_take = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_acc;
      end
    end else if (in_acc) begin
      if (out_vld_r) skid_vld_r <= 1'b1;
      else           out_vld_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_vld_r) begin
      out_res_r <= skid_res_r;
    end else if (in_acc && (!out_vld_r || out_take)) begin
      out_res_r <= res_nxt;
    end
    if (in_acc && out_vld_r && !out_take) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_si_level    = out_res_r.si_level;
  assign out_clock_level = out_res_r.clock_level;
  assign out_pixel_valid = out_res_r.pixel_valid;
  assign out_pixel_index = out_res_r.pixel_index;
  assign out_pixel_value = out_res_r.pixel_value;
  assign out_frame_done  = out_res_r.frame_done;
  assign out_threshold   = out_res_r.threshold;
  assign out_busy_res    = out_res_r.busy_res;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while result register empty");

  a_pixel_ck_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.pixel_valid) |-> (out_res_r.busy_res && !out_res_r.clock_level))
    else $error("pixel captured outside a CK low tick");

  a_done_ck_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.frame_done) |->
      (out_res_r.busy_res && !out_res_r.clock_level && !out_res_r.pixel_valid))
    else $error("frame done on a bad tick");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (dly_cnt_r == '0))
    else $error("delay counter not cleared in idle");

endmodule

/* verif/tb_linear_ccd_readout_threshold_core.sv */
`timescale 1ns / 1ps

module tb_linear_ccd_readout_threshold_core;
  import lccd_pkg::*;

  localparam int NPIX        = PIXELS_DEFAULT;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_TICKS = 70;

  // DUT ports, all inputs known from time zero
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_HALF_PERIOD;
  logic [CFG_W-1:0]     cfg_wdata     = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_start_req  = 1'b0;
  logic [SAMP_W-1:0]    in_adc_sample = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic                 out_si_level;
  logic                 out_clock_level;
  logic                 out_pixel_valid;
  logic [PIX_W-1:0]     out_pixel_index;
  logic [SAMP_W-1:0]    out_pixel_value;
  logic                 out_frame_done;
  logic [SAMP_W-1:0]    out_threshold;
  logic                 out_busy_res;

  // Sequencer shadow: register copies plus readout state
  logic [CFG_W-1:0]  half_period_q = HALF_PERIOD_RESET;
  logic [CFG_W-1:0]  tail_q        = TAIL_RESET;
  phase_t            seq_ph        = PH_IDLE;
  logic [PIX_W-1:0]  pix_cnt       = '0;
  logic [CFG_W-1:0]  dly_cnt       = '0;
  logic [SAMP_W-1:0] run_max       = '0;
  logic [SAMP_W-1:0] run_min       = '0;
  logic [SAMP_W-1:0] thr_q         = '0;

  res_t readout_q[$];
  int   n_err         = 0;
  int   n_sent        = 0;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   hold_req      = 0;
  int   hold_seen     = 0;
  int   hold_left     = 0;

  linear_ccd_readout_threshold_core #(
    .PIXELS(NPIX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_adc_sample  (in_adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_si_level   (out_si_level),
    .out_clock_level(out_clock_level),
    .out_pixel_valid(out_pixel_valid),
    .out_pixel_index(out_pixel_index),
    .out_pixel_value(out_pixel_value),
    .out_frame_done (out_frame_done),
    .out_threshold  (out_threshold),
    .out_busy_res   (out_busy_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the shadow sequencer by one tick and return the pin/pixel beat
  function automatic res_t next_readout(input logic start, input logic [SAMP_W-1:0] sample);
    res_t             r;
    logic [CFG_W-1:0] hp_eff;
    logic [CFG_W-1:0] tail_eff;
    logic [SAMP_W:0]  sum;
    r          = '0;
    r.busy_res = 1'b1;
    hp_eff     = (half_period_q == '0) ? CFG_W'(1) : half_period_q;
    tail_eff   = (tail_q == '0) ? CFG_W'(1) : tail_q;
    case (seq_ph)
      PH_CKUP: begin
        r.si_level    = 1'b1;
        r.clock_level = 1'b1;
        seq_ph        = PH_SIDN;
      end
      PH_SIDN: begin
        r.clock_level = 1'b1;
        pix_cnt       = '0;
        dly_cnt       = '0;
        seq_ph        = PH_LOW;
      end
      PH_LOW: begin
        dly_cnt = dly_cnt + 1'b1;
        if (dly_cnt >= hp_eff) begin
          r.pixel_valid = 1'b1;
          r.pixel_index = pix_cnt;
          r.pixel_value = sample;
          // first pixel of a frame reloads both extremes
          if (pix_cnt == '0) begin
            run_max = sample;
            run_min = sample;
          end else begin
            if (sample > run_max) run_max = sample;
            if (sample < run_min) run_min = sample;
          end
          dly_cnt = '0;
          seq_ph  = PH_HIGH;
        end
      end
      PH_HIGH: begin
        r.clock_level = 1'b1;
        dly_cnt       = dly_cnt + 1'b1;
        if (dly_cnt >= hp_eff) begin
          dly_cnt = '0;
          if (int'(pix_cnt) >= NPIX - 1) begin
            seq_ph = PH_TAIL;
          end else begin
            pix_cnt = pix_cnt + 1'b1;
            seq_ph  = PH_LOW;
          end
        end
      end
      PH_TAIL: begin
        dly_cnt = dly_cnt + 1'b1;
        if (dly_cnt >= tail_eff) begin
          r.frame_done = 1'b1;
          sum          = {1'b0, run_max} + {1'b0, run_min};
          thr_q        = sum[SAMP_W:1];
          dly_cnt      = '0;
          seq_ph       = PH_IDLE;
        end
      end
      default: begin
        seq_ph = PH_IDLE;
        if (start) begin
          r.si_level = 1'b1;
          seq_ph     = PH_CKUP;
        end else begin
          r.busy_res = 1'b0;
        end
      end
    endcase
    r.threshold = thr_q;
    return r;
  endfunction

  // Offer one tick beat, with random idle cycles ahead of it
  task automatic send_tick(input logic start, input logic [SAMP_W-1:0] sample);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_adc_sample <= sample;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    readout_q.push_back(next_readout(start, sample));
    n_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register write once every pending beat has come back
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    go_idle();
    while (readout_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_HALF_PERIOD) half_period_q = data;
    else tail_q = data;
  endtask

  // Feed ticks until the sequencer is back in idle; optionally pin pixel 1 to
  // full scale and pixel 2 to zero
  task automatic finish_frame(input int lo, input int hi, input int start_pct, input bit pin);
    logic [SAMP_W-1:0] s;
    while (seq_ph != PH_IDLE) begin
      s = SAMP_W'($urandom_range(hi, lo));
      if (pin && pix_cnt == PIX_W'(1)) s = '1;
      if (pin && pix_cnt == PIX_W'(2)) s = '0;
      send_tick($urandom_range(99) < start_pct, s);
    end
  endtask

  task automatic run_frame(input int lo, input int hi, input int start_pct);
    send_tick(1'b1, SAMP_W'($urandom));
    finish_frame(lo, hi, start_pct, 1'b0);
  endtask

  // Idle ticks straight out of reset: pins low, not busy, threshold zero
  task automatic test_idle_after_reset();
    send_tick(1'b0, 8'h00);
    send_tick(1'b0, 8'hFF);
    send_tick(1'b0, 8'hAA);
    send_tick(1'b0, 8'h55);
  endtask

  // Reset timing for the SI pulse and early CK low, then zero half period and
  // zero tail; start held high so every busy tick, done included, ignores it
  task automatic test_default_timing();
    send_tick(1'b1, 8'h12);
    repeat (14) send_tick(1'b1, SAMP_W'($urandom));
    write_cfg(CFG_HALF_PERIOD, '0);
    write_cfg(CFG_TAIL, '0);
    finish_frame(0, 255, 100, 1'b1);
  endtask

  // Flat frame after a full-range one: min must reload, not carry over
  task automatic test_threshold_reload();
    write_cfg(CFG_HALF_PERIOD, CFG_W'(1));
    write_cfg(CFG_TAIL, CFG_W'(1));
    run_frame(200, 200, 0);
    send_tick(1'b0, 8'h00);
  endtask

  // Largest half period and tail, cut short by live register writes
  task automatic test_extreme_counts();
    write_cfg(CFG_HALF_PERIOD, '1);
    write_cfg(CFG_TAIL, '1);
    send_tick(1'b1, SAMP_W'($urandom));
    repeat (20) send_tick(1'b0, SAMP_W'($urandom));
    write_cfg(CFG_HALF_PERIOD, CFG_W'(1));
    while (seq_ph != PH_TAIL) send_tick(1'($urandom_range(1)), SAMP_W'($urandom));
    repeat (20) send_tick(1'($urandom_range(1)), SAMP_W'($urandom));
    write_cfg(CFG_TAIL, '0);
    finish_frame(0, 255, 50, 1'b0);
  endtask

  // Random ticks with random settings; a frame may run on into the next phase
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input bit pressure);
    int first;
    int lo;
    int hi;
    int start_pct;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    write_cfg(CFG_HALF_PERIOD, CFG_W'($urandom_range(1)));
    write_cfg(CFG_TAIL, ($urandom_range(3) == 0) ? '0 : CFG_W'($urandom_range(40)));
    first     = n_sent;
    lo        = $urandom_range(255);
    hi        = $urandom_range(255, lo);
    start_pct = $urandom_range(100, 20);
    // long receiver hold-off while ticks keep coming
    if (pressure) hold_req++;
    while (n_sent - first < PHASE_TICKS) begin
      send_tick($urandom_range(99) < start_pct, SAMP_W'($urandom_range(hi, lo)));
    end
    in_idle_pct   = 0;
    out_stall_pct = 0;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Receiver hold-off length, counted in cycles
  always @(posedge clk) begin : hold_counter
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: check each accepted beat, then pick next ready
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (readout_q.size() == 0) begin
        n_err++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = readout_q.pop_front();
        cmp_field("si_level", 16'(want.si_level), 16'(out_si_level));
        cmp_field("clock_level", 16'(want.clock_level), 16'(out_clock_level));
        cmp_field("pixel_valid", 16'(want.pixel_valid), 16'(out_pixel_valid));
        cmp_field("pixel_index", 16'(want.pixel_index), 16'(out_pixel_index));
        cmp_field("pixel_value", 16'(want.pixel_value), 16'(out_pixel_value));
        cmp_field("frame_done", 16'(want.frame_done), 16'(out_frame_done));
        cmp_field("threshold", 16'(want.threshold), 16'(out_threshold));
        cmp_field("busy_res", 16'(want.busy_res), 16'(out_busy_res));
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_after_reset();
    test_default_timing();
    test_threshold_reload();
    test_extreme_counts();
    test_random_traffic(0, 0, 1'b1);
    test_random_traffic(45, 0, 1'b0);
    test_random_traffic(0, 45, 1'b0);
    test_random_traffic(36, 36, 1'b0);
    // drain, then wait for any stray beat
    go_idle();
    while (readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (n_err == 0 && readout_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
